// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define UDFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define UDFF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/udff_pkg.sv -----
// ----------------------------------------------------------------------------
// udff_pkg
// Types, constants and helpers for the unsigned decimal field formatter.
// ----------------------------------------------------------------------------
package udff_pkg;

  localparam int VALUE_W  = 64;
  localparam int LMOD_W   = 2;
  localparam int FWIDTH_W = 6;
  localparam int PREC_W   = 7;
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 7;  // field lengths up to 127
  localparam int CNT_W    = 6;  // pad / precision-zero counters
  localparam int BITCNT_W = 7;  // conversion bit counter, up to 64

  localparam logic [LMOD_W-1:0] LMOD_BYTE = 2'd1;
  localparam logic [LMOD_W-1:0] LMOD_HALF = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_PLAN_A,
    ST_PLAN_B,
    ST_PLAN_C,
    ST_LEAD,
    ST_ZEROS,
    ST_DIGITS,
    ST_COMMA,
    ST_TRAIL
  } udff_state_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_CONV,
    DP_PLAN_A,
    DP_PLAN_B,
    DP_PLAN_C
  } dp_op_e;

  typedef enum logic [2:0] {
    SEL_LEAD,
    SEL_ZERO,
    SEL_DIGIT,
    SEL_COMMA,
    SEL_TRAIL
  } char_sel_e;

  typedef struct packed {
    dp_op_e    op;
    logic      emit;
    char_sel_e sel;
  } udff_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic pad_zero;
    logic pz_zero;
    logic nd_zero;
    logic j_zero;
    logic comma_due;
    logic field_done;
    logic out_space;
    logic left;
  } udff_stat_t;

  // x / 3 for x < 32 as x * 11 >> 5
  function automatic logic [4:0] div3_lt32(input logic [4:0] x);
    logic [9:0] p;
    p = {5'b00000, x} * 10'd11;
    return p[9:5];
  endfunction

endpackage

// ----- rtl/udff_in_if.sv -----
// ----------------------------------------------------------------------------
// udff_in_if
// Input channel: one value to format with its format flags.
// ----------------------------------------------------------------------------
interface udff_in_if import udff_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [LMOD_W-1:0]   length_mod;
  logic [FWIDTH_W-1:0] field_width;
  logic signed [PREC_W-1:0] precision;
  logic                left_justify;
  logic                zero_pad;
  logic                group_thousands;

  modport source (
    output valid, value, length_mod, field_width, precision,
           left_justify, zero_pad, group_thousands,
    input  ready
  );

  modport sink (
    input  valid, value, length_mod, field_width, precision,
           left_justify, zero_pad, group_thousands,
    output ready
  );
endinterface

// ----- rtl/udff_out_if.sv -----
// ----------------------------------------------------------------------------
// udff_out_if
// Output channel: one ASCII character per beat, last marks field end.
// ----------------------------------------------------------------------------
interface udff_out_if import udff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

// ----- rtl/udff_ctrl.sv -----
// ----------------------------------------------------------------------------
// udff_ctrl
// Sequencer: conversion, length planning and per-segment character emission.
// ----------------------------------------------------------------------------
module udff_ctrl import udff_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  udff_stat_t stat_i,
  output udff_cmd_t  cmd_o
);

  udff_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (stat_i.conv_done) state_d = ST_PLAN_A;
      end
      ST_PLAN_A: state_d = ST_PLAN_B;
      ST_PLAN_B: state_d = ST_PLAN_C;
      ST_PLAN_C: state_d = ST_LEAD;
      ST_LEAD: begin
        if (stat_i.field_done) state_d = ST_IDLE;
        else if (stat_i.left || stat_i.pad_zero) state_d = ST_ZEROS;
      end
      ST_ZEROS: begin
        if (stat_i.field_done) state_d = ST_IDLE;
        else if (stat_i.pz_zero) state_d = stat_i.nd_zero ? ST_TRAIL : ST_DIGITS;
      end
      ST_DIGITS: begin
        if (stat_i.field_done) state_d = ST_IDLE;
        else if (stat_i.out_space) begin
          if (stat_i.comma_due) state_d = ST_COMMA;
          else if (stat_i.j_zero) state_d = ST_TRAIL;
        end
      end
      ST_COMMA: begin
        if (stat_i.field_done) state_d = ST_IDLE;
        else if (stat_i.out_space) state_d = ST_DIGITS;
      end
      ST_TRAIL: begin
        if (stat_i.field_done || !stat_i.left || stat_i.pad_zero) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.emit = 1'b0;
    cmd_o.sel  = SEL_LEAD;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      ST_CONV: begin
        if (!stat_i.conv_done) cmd_o.op = DP_CONV;
      end
      ST_PLAN_A: cmd_o.op = DP_PLAN_A;
      ST_PLAN_B: cmd_o.op = DP_PLAN_B;
      ST_PLAN_C: cmd_o.op = DP_PLAN_C;
      ST_LEAD: begin
        cmd_o.sel  = SEL_LEAD;
        cmd_o.emit = !stat_i.field_done && !stat_i.left && !stat_i.pad_zero &&
                     stat_i.out_space;
      end
      ST_ZEROS: begin
        cmd_o.sel  = SEL_ZERO;
        cmd_o.emit = !stat_i.field_done && !stat_i.pz_zero && stat_i.out_space;
      end
      ST_DIGITS: begin
        cmd_o.sel  = SEL_DIGIT;
        cmd_o.emit = !stat_i.field_done && stat_i.out_space;
      end
      ST_COMMA: begin
        cmd_o.sel  = SEL_COMMA;
        cmd_o.emit = !stat_i.field_done && stat_i.out_space;
      end
      ST_TRAIL: begin
        cmd_o.sel  = SEL_TRAIL;
        cmd_o.emit = !stat_i.field_done && stat_i.left && !stat_i.pad_zero &&
                     stat_i.out_space;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/udff_dp.sv -----
// ----------------------------------------------------------------------------
// udff_dp
// Datapath: shift-and-add-3 BCD conversion, field planning, output register.
// ----------------------------------------------------------------------------
module udff_dp import udff_pkg::*; #(
  parameter int MAX_FIELD  = 63,
  parameter int MAX_DIGITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  udff_cmd_t           cmd_i,
  output udff_stat_t          stat_o,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [LMOD_W-1:0]   length_mod_i,
  input  logic [FWIDTH_W-1:0] field_width_i,
  input  logic [PREC_W-1:0]   precision_i,
  input  logic                left_justify_i,
  input  logic                zero_pad_i,
  input  logic                group_thousands_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CHAR_W-1:0]   out_char_o,
  output logic                out_last_o
);

  localparam int NDW = $clog2(MAX_DIGITS + 1);
  localparam int IW  = $clog2(MAX_DIGITS);

  // control state
  logic [BITCNT_W-1:0] bitcnt_q;
  logic [NDW-1:0]      nd_q;
  logic [LEN_W-1:0]    pos_q;
  logic                out_valid_q;

  // payload state
  logic [VALUE_W-1:0]  sh_q;
  logic [3:0]          digit_q [MAX_DIGITS];
  logic [FWIDTH_W-1:0] width_q;
  logic [PREC_W-1:0]   prec_q;
  logic                left_q, zp_q, grp_q;
  logic [4:0]          q3_q;
  logic [CNT_W-1:0]    pz_q, pad_q;
  logic [LEN_W-1:0]    body_q, total_q;
  logic [IW-1:0]       j_q;
  logic [1:0]          mod_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                out_last_q;

  // conversion step
  logic [3:0] adj  [MAX_DIGITS];
  logic [3:0] step [MAX_DIGITS];
  logic       nd_grow;

  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      adj[k] = (digit_q[k] >= 4'd5) ? digit_q[k] + 4'd3 : digit_q[k];
    end
    step[0] = {adj[0][2:0], sh_q[VALUE_W-1]};
    for (int k = 1; k < MAX_DIGITS; k++) begin
      step[k] = {adj[k][2:0], adj[k-1][3]};
    end
  end

  // digit count grows by at most one per doubling
  assign nd_grow = (nd_q < NDW'(MAX_DIGITS)) && (step[nd_q[IW-1:0]] != 4'd0);

  // planning
  logic             prec_given, zero_prec;
  logic [NDW-1:0]   nd_fix, nd_fix_m1, nd_m1;
  logic [LEN_W-1:0] glen, precl, pz_full, widthl, full_len;
  logic [4:0]       q3x3, rem3;

  assign prec_given = !prec_q[PREC_W-1];
  assign zero_prec  = prec_given && (prec_q[PREC_W-2:0] == '0);
  assign nd_fix     = (nd_q == '0 && !zero_prec) ? NDW'(1) : nd_q;
  assign nd_fix_m1  = nd_fix - NDW'(1);
  assign nd_m1      = nd_q - NDW'(1);

  assign glen    = LEN_W'(nd_q) + ((grp_q && nd_q != '0) ? LEN_W'(q3_q) : '0);
  assign precl   = LEN_W'(prec_q[PREC_W-2:0]);
  assign pz_full = (prec_given && precl > glen) ? precl - glen : '0;
  assign q3x3    = q3_q + {q3_q[3:0], 1'b0};
  assign rem3    = 5'(nd_m1) - q3x3;

  assign widthl   = LEN_W'(width_q);
  assign full_len = (widthl > body_q) ? widthl : body_q;

  // emission
  logic              comma_due;
  logic [CHAR_W-1:0] pad_char, emit_char;

  assign comma_due = grp_q && (j_q != '0) && (mod_q == 2'd0);
  assign pad_char  = (zp_q && !left_q && !prec_given) ? CH_ZERO : CH_SPACE;

  always_comb begin
    case (cmd_i.sel)
      SEL_LEAD:  emit_char = pad_char;
      SEL_ZERO:  emit_char = CH_ZERO;
      SEL_DIGIT: emit_char = CH_ZERO + {4'b0000, digit_q[j_q]};
      SEL_COMMA: emit_char = CH_COMMA;
      SEL_TRAIL: emit_char = CH_SPACE;
      default:   emit_char = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitcnt_q    <= '0;
      nd_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_LOAD: begin
          nd_q <= '0;
          case (length_mod_i)
            LMOD_BYTE: bitcnt_q <= BITCNT_W'(8);
            LMOD_HALF: bitcnt_q <= BITCNT_W'(16);
            default:   bitcnt_q <= BITCNT_W'(VALUE_W);
          endcase
        end
        DP_CONV: begin
          bitcnt_q <= bitcnt_q - BITCNT_W'(1);
          if (nd_grow) nd_q <= nd_q + NDW'(1);
        end
        DP_PLAN_A: nd_q <= nd_fix;
        DP_PLAN_C: pos_q <= '0;
        default: ;
      endcase
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_q + LEN_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        width_q <= field_width_i;
        prec_q  <= precision_i;
        left_q  <= left_justify_i;
        zp_q    <= zero_pad_i;
        grp_q   <= group_thousands_i;
        for (int k = 0; k < MAX_DIGITS; k++) digit_q[k] <= 4'd0;
        case (length_mod_i)
          LMOD_BYTE: sh_q <= {value_i[7:0], {(VALUE_W-8){1'b0}}};
          LMOD_HALF: sh_q <= {value_i[15:0], {(VALUE_W-16){1'b0}}};
          default:   sh_q <= value_i;
        endcase
      end
      DP_CONV: begin
        sh_q <= {sh_q[VALUE_W-2:0], 1'b0};
        for (int k = 0; k < MAX_DIGITS; k++) digit_q[k] <= step[k];
      end
      DP_PLAN_A: q3_q <= div3_lt32(5'(nd_fix_m1));
      DP_PLAN_B: begin
        pz_q   <= pz_full[CNT_W-1:0];
        body_q <= glen + pz_full;
        j_q    <= nd_m1[IW-1:0];
        mod_q  <= rem3[1:0];
      end
      DP_PLAN_C: begin
        pad_q   <= (widthl > body_q) ? CNT_W'(widthl - body_q) : '0;
        total_q <= (full_len > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : full_len;
      end
      default: ;
    endcase
    if (cmd_i.emit) begin
      out_char_q <= emit_char;
      out_last_q <= (pos_q + LEN_W'(1)) == total_q;
      case (cmd_i.sel)
        SEL_LEAD, SEL_TRAIL: pad_q <= pad_q - CNT_W'(1);
        SEL_ZERO:            pz_q  <= pz_q - CNT_W'(1);
        SEL_DIGIT, SEL_COMMA: begin
          if (cmd_i.sel == SEL_COMMA || !comma_due) begin
            j_q   <= j_q - IW'(1);
            mod_q <= (mod_q == 2'd0) ? 2'd2 : mod_q - 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat_o.conv_done  = (bitcnt_q == '0);
  assign stat_o.pad_zero   = (pad_q == '0);
  assign stat_o.pz_zero    = (pz_q == '0);
  assign stat_o.nd_zero    = (nd_q == '0);
  assign stat_o.j_zero     = (j_q == '0);
  assign stat_o.comma_due  = comma_due;
  assign stat_o.field_done = (pos_q == total_q);
  assign stat_o.out_space  = !out_valid_q || out_ready_i;
  assign stat_o.left       = left_q;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/unsigned_decimal_field_formatter.sv -----
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter
// printf-style %u formatter: one value in, its text out one character a beat.
// ----------------------------------------------------------------------------
// One value is taken at a time. The value, cut to 8, 16 or 64 bits by
// length_mod, is converted to BCD by shift-and-add-3, one bit a cycle;
// the planning states PLAN_A, PLAN_B and PLAN_C then size the padding,
// precision zeros and commas, and the text streams out at one character
// per cycle while the sink keeps ready high, apart from the moves past an
// empty or finished pad or zero segment, which emit nothing. The next
// value is accepted only after the last character has been loaded into
// the output register. Characters beyond MAX_FIELD are dropped; only the
// low MAX_DIGITS digits are kept.
// ----------------------------------------------------------------------------
module unsigned_decimal_field_formatter import udff_pkg::*; #(
  parameter int MAX_FIELD  = 63,
  parameter int MAX_DIGITS = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  udff_in_if.sink   in_i,
  udff_out_if.source out_o
);

  udff_cmd_t  cmd;   // sequencer -> datapath
  udff_stat_t stat;  // datapath -> sequencer

  // Sequencer: ready only while idle; walks leading pad, precision
  // zeros, digits/commas and trailing pad.
  udff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: BCD digit store, length plan and output beat register.
  udff_dp #(
    .MAX_FIELD  (MAX_FIELD),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .value_i           (in_i.value),
    .length_mod_i      (in_i.length_mod),
    .field_width_i     (in_i.field_width),
    .precision_i       (in_i.precision),
    .left_justify_i    (in_i.left_justify),
    .zero_pad_i        (in_i.zero_pad),
    .group_thousands_i (in_i.group_thousands),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_char_o        (out_o.out_char),
    .out_last_o        (out_o.last)
  );

endmodule

// ----- rtl/udff_checker.sv -----
// ----------------------------------------------------------------------------
// udff_checker
// Port-level assertions for the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udff_checker import udff_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CHAR_W-1:0] out_char_i,
  input logic              out_last_i
);

  // stalled beat holds
  `UDFF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_char_i) && $stable(out_last_i), "output beat changed while stalled")

  // ready is low in the cycle after a value is taken, while conversion runs
  `UDFF_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "ready stayed high after accept")

  // a new value is taken only once the field has reached its last beat
  `UDFF_ASSERT_IMP(a_ready_at_field_end, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i, "ready high mid-field")

endmodule

bind unsigned_decimal_field_formatter udff_checker u_udff_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_last_i  (out_o.last)
);
